// ===== hw/rtl/sau_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack arithmetic unit package
// Shared sizes, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sau_pkg;

	// Stack size and the widths that follow from it.
	localparam int STACK_DEPTH = 64;
	localparam int PTR_W       = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Fixed widths of the request and result fields.
	localparam int MODE_W   = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = 7;

	// Arithmetic needs the top entry and the one below it.
	localparam int MIN_OPERANDS = 2;

	// Number of quotient bits the divider produces, one per cycle.
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [MODE_W-1:0] {
		MODE_NOP  = 3'd0,
		MODE_PUSH = 3'd1,
		MODE_ADD  = 3'd2,
		MODE_SUB  = 3'd3,
		MODE_MUL  = 3'd4,
		MODE_DIV  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;     // capture the request fields
		logic push;      // push the captured value
		logic rd;        // read the entry below the top
		logic alu;       // compute add, sub or mul into the result register
		logic div_start; // load the divider with operand magnitudes
		logic div_step;  // one quotient bit
		logic div_fix;   // apply the quotient sign into the result register
		logic commit;    // replace the two operands by the result
	} sau_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              too_short;
		logic              t_zero;
		logic              div_last;
	} sau_sts_t;

endpackage

// ===== hw/rtl/sau_datapath.sv =====
// ----------------------------------------------------------------------------
// Stack arithmetic unit datapath
// Holds the top of stack in a register and the entries below it in a
// single-port memory, with an adder, a multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module sau_datapath
	import sau_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  sau_cmd_t                 cmd,
	output sau_sts_t                 sts,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [DATA_W-1:0] push_value,
	output logic signed [DATA_W-1:0] top_value,
	output logic [DEPTH_W-1:0]       depth
);

	logic [DATA_W-1:0]    mem_q [STACK_DEPTH];
	logic [MODE_W-1:0]    mode_q;
	logic [DATA_W-1:0]    pv_q;
	logic [DATA_W-1:0]    top_q;
	logic [CNT_W-1:0]     count_q;
	logic [DATA_W-1:0]    second_q;
	logic [DATA_W-1:0]    res_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic [PTR_W-1:0]  wr_addr;
	logic [PTR_W-1:0]  rd_addr;
	logic [DATA_W-1:0] alu_res;
	logic [DATA_W-1:0] mag_s;
	logic [DATA_W-1:0] mag_t;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] trial;

	// Entry below the top sits at count-1 before a push, count-2 for operands.
	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_m2  = count_q - CNT_W'(MIN_OPERANDS);
	assign wr_addr = cnt_m1[PTR_W-1:0];
	assign rd_addr = cnt_m2[PTR_W-1:0];

	// Status toward the controller.
	assign sts.mode      = mode_q;
	assign sts.full      = (count_q >= CNT_W'(STACK_DEPTH));
	assign sts.too_short = (count_q < CNT_W'(MIN_OPERANDS));
	assign sts.t_zero    = (top_q == '0);
	assign sts.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// Result fields; an empty stack reads as zero.
	assign top_value = (count_q == '0) ? '0 : top_q;
	assign depth     = DEPTH_W'(count_q);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			pv_q   <= push_value;
		end
	end

	// Stack memory: the old top moves down on a push, the second entry is read out.
	always_ff @(posedge clk) begin
		if (cmd.push && (count_q != '0)) begin
			mem_q[wr_addr] <= top_q;
		end
		if (cmd.rd) begin
			second_q <= mem_q[rd_addr];
		end
	end

	// Add, subtract and multiply wrap at the data width.
	always_comb begin
		case (mode_q)
			MODE_ADD: alu_res = second_q + top_q;
			MODE_SUB: alu_res = second_q - top_q;
			MODE_MUL: alu_res = second_q * top_q;
			default:  alu_res = '0;
		endcase
	end

	// Operand magnitudes for the divider.
	assign mag_s = second_q[DATA_W-1] ? (DATA_W'(0) - second_q) : second_q;
	assign mag_t = top_q[DATA_W-1] ? (DATA_W'(0) - top_q) : top_q;

	// Restoring division step: shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q     <= '0;
			quo_q     <= mag_s;
			dvs_q     <= mag_t;
			neg_q     <= second_q[DATA_W-1] ^ top_q[DATA_W-1];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (trial[DATA_W+1]) begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// Result register fed by the ALU or the divider.
	always_ff @(posedge clk) begin
		if (cmd.alu) begin
			res_q <= alu_res;
		end else if (cmd.div_fix) begin
			res_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
		end
	end

	// Top of stack and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.commit) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= pv_q;
		end else if (cmd.commit) begin
			top_q <= res_q;
		end
	end

endmodule

// ===== hw/rtl/sau_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack arithmetic unit controller
// Sequences each request through decode and, for arithmetic, operand read,
// execution or the iterative divide, and commit; raises the result strobe.
// ----------------------------------------------------------------------------
module sau_ctrl
	import sau_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output sau_cmd_t            cmd,
	input  sau_sts_t            sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_DIV,
		S_DFIX,
		S_COMMIT
	} state_t;

	state_t  state_q;
	logic    done_q;
	status_t status_q;
	logic    is_arith;

	assign is_arith = sts.mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

	// Datapath commands decoded from the state.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.latch = start;
			S_DECODE: begin
				cmd.push = (sts.mode == MODE_PUSH) && !sts.full;
				cmd.rd   = is_arith && !sts.too_short;
			end
			S_EXEC: begin
				cmd.alu       = (sts.mode != MODE_DIV);
				cmd.div_start = (sts.mode == MODE_DIV) && !sts.t_zero;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_DFIX:   cmd.div_fix = 1'b1;
			S_COMMIT: cmd.commit = 1'b1;
			default:  cmd = '0;
		endcase
	end

	// State and registered result strobe and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.mode == MODE_PUSH) begin
						status_q <= sts.full ? ST_FULL : ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (is_arith && !sts.too_short) begin
						state_q <= S_EXEC;
					end else begin
						status_q <= is_arith ? ST_SHORT : ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_EXEC: begin
					if (sts.mode != MODE_DIV) begin
						state_q <= S_COMMIT;
					end else if (sts.t_zero) begin
						status_q <= ST_DIVZERO;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_DFIX;
					end
				end
				S_DFIX:   state_q <= S_COMMIT;
				S_COMMIT: begin
					status_q <= ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/stack_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// Stack arithmetic unit
// Bounded stack of 32-bit signed integers with push, add, sub, mul and
// truncating div; each request returns the status, new top and new depth.
//
//   Channel   Handshake              Fields
//   request   start && !busy         mode, push_value
//   result    done (one cycle)       status, top_value, depth
//
// A nop, an unused mode, a push, a full-stack push or a short-stack request
// ends in the decode state; a zero divisor ends in the execute state;
// add, sub and mul pass through execute and commit; div passes through
// execute, the one-bit-per-cycle restoring divider, the sign fix and commit.
// busy is low again in the cycle that carries done, so the next request may
// be accepted there. Reset empties the stack; memory contents need no clear.
// The result cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit_core
	import sau_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [DATA_W-1:0]   push_value,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   top_value,
	output logic [DEPTH_W-1:0]         depth
);

	sau_cmd_t cmd;
	sau_sts_t sts;

	// Sequencer.
	sau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Stack storage and arithmetic.
	sau_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.push_value (push_value),
		.top_value  (top_value),
		.depth      (depth)
	);

	// A result never shows while a request is still in progress.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request always occupies the unit in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start");

	// A full-stack rejection reports a full stack.
	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (depth == DEPTH_W'(STACK_DEPTH)))
		else $error("full status with room left");

	// A short-stack rejection reports fewer than two entries.
	a_short_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_SHORT)) |-> (depth < DEPTH_W'(MIN_OPERANDS)))
		else $error("short status with enough operands");

	// The depth holds in the cycle after a result, since a new request
	// cannot change it before its decode cycle ends.
	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (depth == $past(depth)))
		else $error("depth changed outside a request");

endmodule
